// ===== rtl/mbtc_pkg.sv =====
// Shared types and constants for the Modbus TCP reply checker.
`timescale 1ns / 1ps

package mbtc_pkg;

  localparam logic [7:0] FC_READ_HOLDING = 8'h03;
  localparam logic [7:0] FC_EXCEPTION    = 8'h03 | 8'h80;
  localparam logic [7:0] MIN_FRAME_LEN   = 8'd9;
  localparam logic [7:0] POS_MAX         = 8'd255;
  localparam int         DATA_BYTES      = 8;

  localparam logic [0:0] CFG_UNIT_ID      = 1'b0;
  localparam logic [0:0] CFG_RESYNC_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_BYTE    = 2'd1,
    OP_TIMEOUT = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_SHORT     = 4'd1,
    ST_RESYNC    = 4'd2,
    ST_PROTOCOL  = 4'd3,
    ST_UNIT      = 4'd4,
    ST_EXCEPTION = 4'd5,
    ST_FUNCTION  = 4'd6,
    ST_COUNT     = 4'd7,
    ST_TRUNCATED = 4'd8
  } status_t;

  typedef struct packed {
    opcode_t    opcode;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [2:0] register_count;
  } item_t;

  typedef struct packed {
    status_t            status;
    logic [7:0]         exception_code;
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;
    logic [3:0]         payload_length;
    logic [15:0]        transaction_id;
  } result_t;

endpackage

// ===== rtl/mbtc_frame.sv =====
// Transaction and chunk state of the reply checker, with the end-of-chunk checks.
`timescale 1ns / 1ps

module mbtc_frame (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  mbtc_pkg::item_t  item,
  input  logic [7:0]       unit_id,
  input  logic [2:0]       resync_limit,
  output logic             res_valid,
  output mbtc_pkg::result_t res
);

  logic [15:0] txn_r, txn_nxt;
  logic        open_r, open_nxt;
  logic [2:0]  wanted_r, wanted_nxt;
  logic [2:0]  attempt_r, attempt_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [15:0] seen_txn_r, seen_txn_nxt;
  logic        proto_nz_r, proto_nz_nxt;
  logic [7:0]  seen_unit_r, seen_unit_nxt;
  logic [7:0]  seen_func_r, seen_func_nxt;
  logic [7:0]  seen_count_r, seen_count_nxt;
  logic [63:0] data_r, data_nxt;

  // Chunk contents after taking the current byte.
  logic [7:0]  tk_pos;
  logic [15:0] tk_txn;
  logic        tk_proto_nz;
  logic [7:0]  tk_unit, tk_func, tk_count;
  logic [63:0] tk_data;

  // Chunk contents the checks look at (empty for a timeout).
  logic [7:0]  ev_pos;
  logic [15:0] ev_txn;
  logic        ev_proto_nz;
  logic [7:0]  ev_unit, ev_func, ev_count;
  logic [63:0] ev_data, masked;

  logic        finish, drop;
  logic [2:0]  rc_clamped;
  mbtc_pkg::status_t status;

  always_comb begin
    tk_pos      = (pos_r == mbtc_pkg::POS_MAX) ? pos_r : pos_r + 8'd1;
    tk_txn      = seen_txn_r;
    tk_proto_nz = proto_nz_r;
    tk_unit     = seen_unit_r;
    tk_func     = seen_func_r;
    tk_count    = seen_count_r;
    tk_data     = data_r;
    case (pos_r)
      8'd0: tk_txn[15:8] = item.data_byte;
      8'd1: tk_txn[7:0]  = item.data_byte;
      8'd2, 8'd3: tk_proto_nz = proto_nz_r | (item.data_byte != 8'd0);
      8'd6: tk_unit  = item.data_byte;
      8'd7: tk_func  = item.data_byte;
      8'd8: tk_count = item.data_byte;
      default: ;
    endcase
    // Reply bytes 9 to 16 land big-endian, byte 9 in the top lane.
    for (int j = 0; j < mbtc_pkg::DATA_BYTES; j++) begin
      if (pos_r == 8'(9 + j)) tk_data[63 - 8*j -: 8] = item.data_byte;
    end
  end

  always_comb begin
    if (item.opcode == mbtc_pkg::OP_TIMEOUT) begin
      ev_pos = '0; ev_txn = '0; ev_proto_nz = 1'b0;
      ev_unit = '0; ev_func = '0; ev_count = '0; ev_data = '0;
    end else begin
      ev_pos = tk_pos; ev_txn = tk_txn; ev_proto_nz = tk_proto_nz;
      ev_unit = tk_unit; ev_func = tk_func; ev_count = tk_count; ev_data = tk_data;
    end

    masked = ev_data;
    for (int j = 0; j < mbtc_pkg::DATA_BYTES; j++) begin
      if (!(8'(j) < ev_count)) masked[63 - 8*j -: 8] = 8'd0;
    end

    drop = 1'b0;
    if (ev_pos < mbtc_pkg::MIN_FRAME_LEN) status = mbtc_pkg::ST_SHORT;
    else if (ev_txn != txn_r) begin
      drop   = attempt_r < resync_limit;
      status = mbtc_pkg::ST_RESYNC;
    end
    else if (ev_proto_nz)                      status = mbtc_pkg::ST_PROTOCOL;
    else if (ev_unit != unit_id)               status = mbtc_pkg::ST_UNIT;
    else if (ev_func == mbtc_pkg::FC_EXCEPTION) status = mbtc_pkg::ST_EXCEPTION;
    else if (ev_func != mbtc_pkg::FC_READ_HOLDING) status = mbtc_pkg::ST_FUNCTION;
    else if (ev_count != {4'd0, wanted_r, 1'b0}) status = mbtc_pkg::ST_COUNT;
    else if ({1'b0, ev_pos} < 9'd9 + {1'b0, ev_count}) status = mbtc_pkg::ST_TRUNCATED;
    else status = mbtc_pkg::ST_OK;

    res.status         = status;
    res.exception_code = (status == mbtc_pkg::ST_EXCEPTION) ? ev_count : 8'd0;
    res.first_value    = (status == mbtc_pkg::ST_OK) ? masked[63:32] : 32'sd0;
    res.second_value   = (status == mbtc_pkg::ST_OK) ? masked[31:0] : 32'sd0;
    res.payload_length = (status == mbtc_pkg::ST_OK) ? 4'd3 + ev_count[3:0] : 4'd0;
    res.transaction_id = txn_r;
  end

  always_comb begin
    rc_clamped = item.register_count;
    if (rc_clamped == 3'd0) rc_clamped = 3'd1;
    if (rc_clamped > 3'd4)  rc_clamped = 3'd4;

    txn_nxt        = txn_r;
    open_nxt       = open_r;
    wanted_nxt     = wanted_r;
    attempt_nxt    = attempt_r;
    pos_nxt        = pos_r;
    seen_txn_nxt   = seen_txn_r;
    proto_nz_nxt   = proto_nz_r;
    seen_unit_nxt  = seen_unit_r;
    seen_func_nxt  = seen_func_r;
    seen_count_nxt = seen_count_r;
    data_nxt       = data_r;
    finish         = 1'b0;
    res_valid      = 1'b0;

    if (step) begin
      case (item.opcode)
        mbtc_pkg::OP_START: begin
          txn_nxt     = txn_r + 16'd1;
          open_nxt    = 1'b1;
          wanted_nxt  = rc_clamped;
          attempt_nxt = 3'd0;
          finish      = 1'b0;
        end
        mbtc_pkg::OP_BYTE: begin
          pos_nxt        = tk_pos;
          seen_txn_nxt   = tk_txn;
          proto_nz_nxt   = tk_proto_nz;
          seen_unit_nxt  = tk_unit;
          seen_func_nxt  = tk_func;
          seen_count_nxt = tk_count;
          data_nxt       = tk_data;
          finish         = item.last_byte;
        end
        mbtc_pkg::OP_TIMEOUT: finish = 1'b1;
        default: ;
      endcase

      // A start, a finished chunk and a timeout all leave an empty chunk behind.
      if (item.opcode == mbtc_pkg::OP_START || finish) begin
        pos_nxt = '0; seen_txn_nxt = '0; proto_nz_nxt = 1'b0;
        seen_unit_nxt = '0; seen_func_nxt = '0; seen_count_nxt = '0; data_nxt = '0;
      end

      if (finish && open_r) begin
        if (drop) begin
          attempt_nxt = attempt_r + 3'd1;
        end else begin
          res_valid = 1'b1;
          open_nxt  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      txn_r        <= '0;
      open_r       <= 1'b0;
      wanted_r     <= '0;
      attempt_r    <= '0;
      pos_r        <= '0;
      seen_txn_r   <= '0;
      proto_nz_r   <= 1'b0;
      seen_unit_r  <= '0;
      seen_func_r  <= '0;
      seen_count_r <= '0;
      data_r       <= '0;
    end else begin
      txn_r        <= txn_nxt;
      open_r       <= open_nxt;
      wanted_r     <= wanted_nxt;
      attempt_r    <= attempt_nxt;
      pos_r        <= pos_nxt;
      seen_txn_r   <= seen_txn_nxt;
      proto_nz_r   <= proto_nz_nxt;
      seen_unit_r  <= seen_unit_nxt;
      seen_func_r  <= seen_func_nxt;
      seen_count_r <= seen_count_nxt;
      data_r       <= data_nxt;
    end
  end

endmodule

// ===== rtl/modbus_tcp_reply_checker_unit.sv =====
// Top level of the Modbus TCP read-holding-registers reply checker.
// Input stream: one request per clock while in_tready is high; tuser carries
// the opcode (start, reply byte, timeout), tdata the reply byte and the
// register count, tlast the end of a received chunk. Output stream: one result
// per finished chunk or timeout of an open transaction, with the status in
// tuser and the exception code, both 32-bit values, payload length and
// transaction id in tdata. Stale replies are dropped silently while resync
// attempts remain. Each accepted request waits in the input register, and its
// result is loaded into the output register when the request advances.
// Throughput is one request per cycle while the receiver does not stall; the
// frame unit updates the chunk state for each request as it advances.
// When the receiver stalls, the pending result holds and the input register
// still fills; in_tready drops only once both are occupied.
// Configuration writes (unit id, resync limit) take effect the next cycle.
// Reset is synchronous: it closes any transaction, clears the chunk and
// transaction id, restores unit id 1 and resync limit 3, and empties both
// registers.
`timescale 1ns / 1ps

module modbus_tcp_reply_checker_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] data_byte, [10:8] register_count, rest zero
  input  logic        in_tlast,
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // [7:0] exception_code, [39:8] first_value,
                                  // [71:40] second_value, [75:72] payload_length,
                                  // [91:76] transaction_id, rest zero
  output logic [3:0]  out_tuser,  // [3:0] status
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [7:0]        unit_id_r;
  logic [2:0]        resync_limit_r;
  logic              stage_valid_r;
  mbtc_pkg::item_t   stage_item_r;
  logic              out_valid_r;
  mbtc_pkg::result_t out_res_r;
  logic              advance;
  logic              res_valid;
  mbtc_pkg::result_t res;

  assign advance   = stage_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !stage_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_id_r      <= 8'd1;
      resync_limit_r <= 3'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        mbtc_pkg::CFG_UNIT_ID:      unit_id_r      <= cfg_data;
        mbtc_pkg::CFG_RESYNC_LIMIT: resync_limit_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_tready) begin
      stage_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      stage_item_r.opcode         <= mbtc_pkg::opcode_t'(in_tuser);
      stage_item_r.data_byte      <= in_tdata[7:0];
      stage_item_r.last_byte      <= in_tlast;
      stage_item_r.register_count <= in_tdata[10:8];
    end
  end

  mbtc_frame u_frame (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance),
    .item         (stage_item_r),
    .unit_id      (unit_id_r),
    .resync_limit (resync_limit_r),
    .res_valid    (res_valid),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {4'd0, out_res_r.transaction_id, out_res_r.payload_length,
                       out_res_r.second_value, out_res_r.first_value,
                       out_res_r.exception_code};

  // A held request must not be lost while the result register is blocked.
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    stage_valid_r && out_valid_r && !out_tready |=> stage_valid_r)
    else $error("input register lost a request under stall");

  // Only a successful check carries data and a payload length.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != mbtc_pkg::ST_OK |->
      out_tdata[75:8] == 68'd0)
    else $error("failure result carries data");

  a_ok_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == mbtc_pkg::ST_OK |->
      out_tdata[75:72] >= 4'd5 && out_tdata[75:72] <= 4'd11 && out_tdata[7:0] == 8'd0)
    else $error("successful result has a bad payload length");

  // Nothing comes out in the cycle after reset is released.
  a_reset_quiet: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

endmodule
